>>> sv/bfsk_modulator_nco_assert.svh
// Assertion macros for the binary FSK modulator.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef BFSK_MODULATOR_NCO_ASSERT_SVH
`define BFSK_MODULATOR_NCO_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFSK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFSK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bfsk_pkg.sv
// Shared types, constants and the cosine table function of the FSK modulator.
// It depends on nothing else and is compiled before every module.
package bfsk_pkg;

  localparam int unsigned AmpWidth     = 15;
  localparam int unsigned StepWidth    = 32;
  localparam int unsigned SpbWidth     = 16;
  localparam int unsigned PatWidth     = 64;
  localparam int unsigned LenWidth     = 7;
  localparam int unsigned PosWidth     = 6;
  localparam int unsigned SampleWidth  = 16;
  localparam int unsigned MagWidth     = 15;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 64;

  localparam logic [LenWidth-1:0] MaxPattern = 7'd64;

  localparam logic [63:0] Q30One   = 64'd1073741824;
  localparam logic [63:0] TwoPiQ30 = 64'd6746518852;
  localparam logic [63:0] MagMax   = 64'd32767;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_AMPLITUDE      = 3'd0,
    CFG_SPACE_STEP     = 3'd1,
    CFG_MARK_STEP      = 3'd2,
    CFG_SAMPLES_PER_BIT = 3'd3,
    CFG_BIT_PATTERN    = 3'd4,
    CFG_PATTERN_LENGTH = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic [AmpWidth-1:0]  amplitude;
    logic [StepWidth-1:0] space_phase_step;
    logic [StepWidth-1:0] mark_phase_step;
    logic [SpbWidth-1:0]  samples_per_bit;
    logic [PatWidth-1:0]  bit_pattern;
    logic [LenWidth-1:0]  pattern_length;
  } cfg_regs_t;

  typedef struct packed {
    logic                neg;
    logic [MagWidth-1:0] mag;
    logic                bit_val;
  } lut_out_t;

  // Quarter-wave cosine magnitude for table index r, on a 32767 scale.
  // Only evaluated at elaboration to build the constant table.
  function automatic logic [MagWidth-1:0] cos_quarter(input int unsigned r,
                                                      input int unsigned addr_bits);
    logic [63:0] n;
    logic [63:0] quarter;
    logic [63:0] eighth;
    logic [63:0] rr;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    logic        sine;
    longint      sum;
    n       = 64'd1 << addr_bits;
    quarter = n >> 2;
    eighth  = n >> 3;
    rr      = 64'(r);
    sine    = (rr > eighth);
    if (sine) begin
      rr = quarter - rr;
    end
    x  = (rr * TwoPiQ30 + (n >> 1)) >> addr_bits;
    x2 = (x * x) >> 30;
    if (sine) begin
      term = x;
      sum  = $signed(term);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
    end else begin
      term = Q30One;
      sum  = $signed(term);
      term = ((term * x2) >> 30) / 64'd2;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd12;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd30;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd56;
      sum  = sum + $signed(term);
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = ($unsigned(sum) * MagMax + (64'd1 << 29)) >> 30;
    if (v > MagMax) begin
      v = MagMax;
    end
    return v[MagWidth-1:0];
  endfunction

endpackage

>>> sv/bfsk_cfg_regs.sv
// Configuration register file of the FSK modulator.
// Depends on bfsk_pkg for the register indexes and the register struct.
module bfsk_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [bfsk_pkg::CfgIdxWidth-1:0]    wr_index_i,
  input  logic [bfsk_pkg::CfgDataWidth-1:0]   wr_data_i,
  output bfsk_pkg::cfg_regs_t                 cfg_o
);
  import bfsk_pkg::*;

  cfg_regs_t cfg_q;
  cfg_regs_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_index_e'(wr_index_i))
        CFG_AMPLITUDE:       cfg_d.amplitude        = wr_data_i[AmpWidth-1:0];
        CFG_SPACE_STEP:      cfg_d.space_phase_step = wr_data_i[StepWidth-1:0];
        CFG_MARK_STEP:       cfg_d.mark_phase_step  = wr_data_i[StepWidth-1:0];
        CFG_SAMPLES_PER_BIT: cfg_d.samples_per_bit  = wr_data_i[SpbWidth-1:0];
        CFG_BIT_PATTERN:     cfg_d.bit_pattern      = wr_data_i[PatWidth-1:0];
        CFG_PATTERN_LENGTH:  cfg_d.pattern_length   = wr_data_i[LenWidth-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.amplitude        <= '0;
      cfg_q.space_phase_step <= '0;
      cfg_q.mark_phase_step  <= '0;
      cfg_q.samples_per_bit  <= SpbWidth'(1);
      cfg_q.bit_pattern      <= '0;
      cfg_q.pattern_length   <= LenWidth'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/bfsk_nco_core.sv
// Phase accumulator, sample and bit counters and the first pipeline register.
// Depends on bfsk_pkg for the configuration struct and field widths.
module bfsk_nco_core #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bfsk_pkg::cfg_regs_t         cfg_i,
  input  logic                        in_valid_i,
  input  logic                        restart_i,
  output logic                        in_ready_o,
  input  logic                        s1_ready_i,
  output logic                        s1_valid_o,
  output logic [TABLE_ADDR_BITS-1:0]  s1_addr_o,
  output logic                        s1_bit_o
);
  import bfsk_pkg::*;

  logic [PHASE_BITS-1:0]      phase_q, phase_d, base_phase;
  logic [SpbWidth-1:0]        sib_q, sib_d, base_sib;
  logic [PosWidth-1:0]        pos_q, pos_d, base_pos;
  logic [SpbWidth-1:0]        spb_eff;
  logic [LenWidth-1:0]        len_eff;
  logic [SpbWidth:0]          sib_inc;
  logic [LenWidth-1:0]        pos_inc;
  logic [StepWidth-1:0]       step_sel;
  logic                       bit_sel;
  logic                       accept;
  logic                       s1_valid_q;
  logic [TABLE_ADDR_BITS-1:0] s1_addr_q;
  logic                       s1_bit_q;

  assign in_ready_o = ~s1_valid_q | s1_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    base_phase = restart_i ? '0 : phase_q;
    base_sib   = restart_i ? '0 : sib_q;
    base_pos   = restart_i ? '0 : pos_q;

    spb_eff = (cfg_i.samples_per_bit == '0) ? SpbWidth'(1) : cfg_i.samples_per_bit;
    if (cfg_i.pattern_length == '0) begin
      len_eff = LenWidth'(1);
    end else if (cfg_i.pattern_length > MaxPattern) begin
      len_eff = MaxPattern;
    end else begin
      len_eff = cfg_i.pattern_length;
    end

    bit_sel  = cfg_i.bit_pattern[base_pos];
    step_sel = bit_sel ? cfg_i.mark_phase_step : cfg_i.space_phase_step;
    phase_d  = base_phase + PHASE_BITS'(step_sel);

    sib_inc = {1'b0, base_sib} + (SpbWidth+1)'(1);
    pos_inc = {1'b0, base_pos} + LenWidth'(1);
    pos_d   = base_pos;
    if (sib_inc >= {1'b0, spb_eff}) begin
      sib_d = '0;
      pos_d = (pos_inc >= len_eff) ? '0 : pos_inc[PosWidth-1:0];
    end else begin
      sib_d = sib_inc[SpbWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      sib_q      <= '0;
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        sib_q   <= sib_d;
        pos_q   <= pos_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q <= phase_d[PHASE_BITS-1 -: TABLE_ADDR_BITS];
      s1_bit_q  <= bit_sel;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_addr_o  = s1_addr_q;
  assign s1_bit_o   = s1_bit_q;

endmodule

>>> sv/bfsk_cos_lut.sv
// Quarter-wave folding and constant cosine table, registered into stage two.
// Depends on bfsk_pkg for the table function and the stage payload struct.
module bfsk_cos_lut #(
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s1_valid_i,
  input  logic [TABLE_ADDR_BITS-1:0]  s1_addr_i,
  input  logic                        s1_bit_i,
  output logic                        s1_ready_o,
  input  logic                        s2_ready_i,
  output logic                        s2_valid_o,
  output bfsk_pkg::lut_out_t          s2_o
);
  import bfsk_pkg::*;

  localparam int unsigned TblDepth = (2 ** (TABLE_ADDR_BITS - 2)) + 1;
  localparam logic [TABLE_ADDR_BITS-1:0] Half    = {1'b1, {(TABLE_ADDR_BITS-1){1'b0}}};
  localparam logic [TABLE_ADDR_BITS-1:0] Quarter = {2'b01, {(TABLE_ADDR_BITS-2){1'b0}}};

  logic [MagWidth-1:0]        cos_tbl [TblDepth];
  logic [TABLE_ADDR_BITS-1:0] fold_half;
  logic [TABLE_ADDR_BITS-1:0] fold_quarter;
  logic                       neg;
  logic                       load;
  logic                       s2_valid_q;
  lut_out_t                   s2_q;
  lut_out_t                   s2_d;

  for (genvar g = 0; g < TblDepth; g++) begin : g_tbl
    localparam logic [MagWidth-1:0] Entry = cos_quarter(g, TABLE_ADDR_BITS);
    assign cos_tbl[g] = Entry;
  end

  always_comb begin
    fold_half = (s1_addr_i > Half) ? (TABLE_ADDR_BITS'(0) - s1_addr_i) : s1_addr_i;
    neg       = (fold_half > Quarter);
    fold_quarter = neg ? (Half - fold_half) : fold_half;
    s2_d.neg     = neg;
    s2_d.mag     = cos_tbl[fold_quarter[TABLE_ADDR_BITS-2:0]];
    s2_d.bit_val = s1_bit_i;
  end

  assign s1_ready_o = ~s2_valid_q | s2_ready_i;
  assign load       = s1_valid_i & s1_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      s2_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s2_q <= s2_d;
    end
  end

  assign s2_valid_o = s2_valid_q;
  assign s2_o       = s2_q;

endmodule

>>> sv/bfsk_scale.sv
// Amplitude multiply with floor shift and the output register.
// Depends on bfsk_pkg for the stage payload struct and field widths.
module bfsk_scale (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [bfsk_pkg::AmpWidth-1:0]       amplitude_i,
  input  logic                                s2_valid_i,
  input  bfsk_pkg::lut_out_t                  s2_i,
  output logic                                s2_ready_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bfsk_pkg::SampleWidth-1:0] sample_o,
  output logic                                current_bit_o
);
  import bfsk_pkg::*;

  localparam int unsigned ProdWidth = AmpWidth + MagWidth;

  logic [ProdWidth-1:0]   prod;
  logic [ProdWidth:0]     prod_up;
  logic [SampleWidth-1:0] neg_mag;
  logic [SampleWidth-1:0] sample_d;
  logic                   load;
  logic                   out_valid_q;
  logic [SampleWidth-1:0] sample_q;
  logic                   bit_q;

  always_comb begin
    prod     = ProdWidth'(amplitude_i) * ProdWidth'(s2_i.mag);
    prod_up  = {1'b0, prod} + (ProdWidth+1)'(MagMax);
    neg_mag  = prod_up[ProdWidth -: SampleWidth];
    sample_d = s2_i.neg ? (SampleWidth'(0) - neg_mag)
                        : {1'b0, prod[ProdWidth-1 -: (SampleWidth-1)]};
  end

  assign s2_ready_o = ~out_valid_q | ~out_stall_i;
  assign load       = s2_valid_i & s2_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready_o) begin
      out_valid_q <= s2_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q <= sample_d;
      bit_q    <= s2_i.bit_val;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_o      = $signed(sample_q);
  assign current_bit_o = bit_q;

endmodule

>>> sv/bfsk_modulator_nco.sv
// Binary FSK modulator built as a numerically controlled oscillator.
// Each accepted beat on the input channel yields one sample beat on the output.
// A beat carries restart_i; when it is set the phase and both counters are
// cleared before the sample is formed. The configuration channel writes one
// register per beat (index 0 amplitude, 1 space step, 2 mark step, 3 samples
// per bit, 4 bit pattern, 5 pattern length) and is always ready.
// An accepted input beat passes three registers on the way to its output beat:
// the phase add, the cosine table lookup and the amplitude multiply each
// end in a register. Throughput is one beat per cycle while the output is
// not stalled, set by the phase accumulator loop, which closes through one register.
// Stall on the output holds the result register; the two inner stages keep
// filling, so the input is stalled only once all three registers are full.
// Reset clears the phase, the counters, every valid flag and the registers
// to their defaults (samples per bit and pattern length one, others zero).
// Depends on bfsk_pkg, the stage modules and bfsk_modulator_nco_assert.svh.
module bfsk_modulator_nco #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic                                     restart_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [bfsk_pkg::SampleWidth-1:0]  sample_o,
  output logic                                     current_bit_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [bfsk_pkg::CfgIdxWidth-1:0]         cfg_index_i,
  input  logic [bfsk_pkg::CfgDataWidth-1:0]        cfg_data_i
);
  import bfsk_pkg::*;

  `include "bfsk_modulator_nco_assert.svh"

  cfg_regs_t                  cfg;
  logic                       in_ready;
  logic                       s1_valid;
  logic                       s1_ready;
  logic [TABLE_ADDR_BITS-1:0] s1_addr;
  logic                       s1_bit;
  logic                       s2_valid;
  logic                       s2_ready;
  lut_out_t                   s2;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = ~in_ready;

  bfsk_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  bfsk_nco_core #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_nco_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .in_ready_o (in_ready),
    .s1_ready_i (s1_ready),
    .s1_valid_o (s1_valid),
    .s1_addr_o  (s1_addr),
    .s1_bit_o   (s1_bit)
  );

  bfsk_cos_lut #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_cos_lut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_addr_i  (s1_addr),
    .s1_bit_i   (s1_bit),
    .s1_ready_o (s1_ready),
    .s2_ready_i (s2_ready),
    .s2_valid_o (s2_valid),
    .s2_o       (s2)
  );

  bfsk_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .amplitude_i   (cfg.amplitude),
    .s2_valid_i    (s2_valid),
    .s2_i          (s2),
    .s2_ready_o    (s2_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_o      (sample_o),
    .current_bit_o (current_bit_o)
  );

  `BFSK_ASSERT_NEXT(a_restart_first_bit, in_valid_i && !in_stall_o && restart_i, s1_valid && (s1_bit == $past(cfg.bit_pattern[0])), "restart did not select pattern bit zero")
  `BFSK_ASSERT_SAME(a_stall_only_when_full, in_stall_o, s1_valid && s2_valid && out_valid_o, "input stalled with an empty pipeline stage")
  `BFSK_ASSERT_SAME(a_sample_range, out_valid_o, sample_o != 16'sh8000, "sample outside the cosine scale")

endmodule
